// ===== rtl/skt_pkg.sv =====
package skt_pkg;

	localparam int unsigned ColCount   = 256;
	localparam int unsigned ColW       = $clog2(ColCount);
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned CountW     = 15;
	localparam int unsigned PosW       = 11;
	localparam int unsigned InBlkW     = 7;
	localparam int unsigned ChromaW    = 25;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// bt.601 chroma coefficients in q16, offset of 128 in q16
	localparam logic signed [ChromaW-1:0] ChromaBase = 25'sd8388608;
	localparam logic signed [ChromaW-1:0] CoefCbB    = 25'sd28770;
	localparam logic signed [ChromaW-1:0] CoefCbR    = 25'sd9699;
	localparam logic signed [ChromaW-1:0] CoefCbG    = 25'sd19071;
	localparam logic signed [ChromaW-1:0] CoefCrR    = 25'sd28770;
	localparam logic signed [ChromaW-1:0] CoefCrG    = 25'sd24117;
	localparam logic signed [ChromaW-1:0] CoefCrB    = 25'sd4653;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_BLOCK  = 3'd2,
		REG_THRESH = 3'd3,
		REG_CB     = 3'd4,
		REG_CR     = 3'd5,
		REG_RANGE  = 3'd6
	} skt_reg_t;

	typedef struct packed {
		logic [PosW-1:0]   wm1;
		logic [PosW-1:0]   hm1;
		logic [InBlkW-1:0] bsm1;
		logic [CountW-1:0] thresh;
		logic [7:0]        cb_center;
		logic [7:0]        cr_center;
		logic [7:0]        half_range;
	} skt_cfg_t;

	typedef struct packed {
		logic            skin;
		logic [ColW-1:0] block_col;
		logic [7:0]      block_row;
		logic            emit;
		logic            frame_done;
		logic            frame_start;
	} skt_item_t;

endpackage

// ===== rtl/skt_front.sv =====
module skt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  skt_pkg::skt_cfg_t  cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic               frame_start,
	output logic               push,
	output skt_pkg::skt_item_t push_item,
	input  logic               q_full
);

	logic                           move;
	logic                           accept;

	logic [skt_pkg::PosW-1:0]       pixel_x_q, pixel_y_q;
	logic [skt_pkg::InBlkW-1:0]     x_in_block_q, y_in_block_q;
	logic [skt_pkg::ColW-1:0]       block_x_q;
	logic [7:0]                     block_y_q;

	logic [skt_pkg::PosW-1:0]       cur_px, cur_py, nxt_px, nxt_py;
	logic [skt_pkg::InBlkW-1:0]     cur_xib, cur_yib, nxt_xib, nxt_yib;
	logic [skt_pkg::ColW-1:0]       cur_bx, nxt_bx;
	logic [7:0]                     cur_by, nxt_by;
	logic                           row_end, col_end, bx_end, by_end;

	logic                           valid_s1;
	logic [7:0]                     red_s1, green_s1, blue_s1;
	logic [skt_pkg::ColW-1:0]       col_s1;
	logic [7:0]                     row_s1;
	logic                           emit_s1, done_s1, start_s1;

	logic signed [skt_pkg::ChromaW-1:0] r_ext, g_ext, b_ext, cb_sum, cr_sum;

	logic                           valid_s2;
	logic [7:0]                     cb_s2, cr_s2;
	logic [skt_pkg::ColW-1:0]       col_s2;
	logic [7:0]                     row_s2;
	logic                           emit_s2, done_s2, start_s2;

	logic signed [9:0]              cb_v, cr_v, cb_lo, cb_hi, cr_lo, cr_hi;
	logic                           skin;

	assign move     = !(valid_s2 && q_full);
	assign in_stall = !move;
	assign accept   = in_valid && move;
	assign push     = valid_s2 && move;

	// position tracking, frame start restarts at the origin
	always_comb begin
		cur_px  = frame_start ? '0 : pixel_x_q;
		cur_py  = frame_start ? '0 : pixel_y_q;
		cur_xib = frame_start ? '0 : x_in_block_q;
		cur_yib = frame_start ? '0 : y_in_block_q;
		cur_bx  = frame_start ? '0 : block_x_q;
		cur_by  = frame_start ? '0 : block_y_q;

		row_end = cur_px >= cfg.wm1;
		col_end = cur_py >= cfg.hm1;
		bx_end  = row_end || (cur_xib >= cfg.bsm1);
		by_end  = col_end || (cur_yib >= cfg.bsm1);

		nxt_px  = cur_px;
		nxt_py  = cur_py;
		nxt_xib = cur_xib;
		nxt_yib = cur_yib;
		nxt_bx  = cur_bx;
		nxt_by  = cur_by;
		if (row_end) begin
			nxt_px  = '0;
			nxt_xib = '0;
			nxt_bx  = '0;
			if (col_end) begin
				nxt_py  = '0;
				nxt_yib = '0;
				nxt_by  = '0;
			end else begin
				nxt_py = cur_py + 1'b1;
				if (by_end) begin
					nxt_yib = '0;
					nxt_by  = cur_by + 1'b1;
				end else begin
					nxt_yib = cur_yib + 1'b1;
				end
			end
		end else begin
			nxt_px = cur_px + 1'b1;
			if (bx_end) begin
				nxt_xib = '0;
				nxt_bx  = cur_bx + 1'b1;
			end else begin
				nxt_xib = cur_xib + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q    <= '0;
			pixel_y_q    <= '0;
			x_in_block_q <= '0;
			y_in_block_q <= '0;
			block_x_q    <= '0;
			block_y_q    <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (accept) begin
				pixel_x_q    <= nxt_px;
				pixel_y_q    <= nxt_py;
				x_in_block_q <= nxt_xib;
				y_in_block_q <= nxt_yib;
				block_x_q    <= nxt_bx;
				block_y_q    <= nxt_by;
			end
			if (move) begin
				valid_s1 <= accept;
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			col_s1   <= cur_bx;
			row_s1   <= cur_by;
			emit_s1  <= bx_end && by_end;
			done_s1  <= row_end && col_end;
			start_s1 <= frame_start;
		end
		if (move) begin
			cb_s2    <= cb_sum[23:16];
			cr_s2    <= cr_sum[23:16];
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			emit_s2  <= emit_s1;
			done_s2  <= done_s1;
			start_s2 <= start_s1;
		end
	end

	// q16 chroma, always positive so the floor is a plain bit slice
	always_comb begin
		r_ext  = $signed({17'd0, red_s1});
		g_ext  = $signed({17'd0, green_s1});
		b_ext  = $signed({17'd0, blue_s1});
		cb_sum = skt_pkg::ChromaBase + skt_pkg::CoefCbB * b_ext
			- skt_pkg::CoefCbR * r_ext - skt_pkg::CoefCbG * g_ext;
		cr_sum = skt_pkg::ChromaBase + skt_pkg::CoefCrR * r_ext
			- skt_pkg::CoefCrG * g_ext - skt_pkg::CoefCrB * b_ext;
	end

	always_comb begin
		cb_v  = $signed({2'b00, cb_s2});
		cr_v  = $signed({2'b00, cr_s2});
		cb_lo = $signed({2'b00, cfg.cb_center}) - $signed({2'b00, cfg.half_range});
		cb_hi = $signed({2'b00, cfg.cb_center}) + $signed({2'b00, cfg.half_range});
		cr_lo = $signed({2'b00, cfg.cr_center}) - $signed({2'b00, cfg.half_range});
		cr_hi = $signed({2'b00, cfg.cr_center}) + $signed({2'b00, cfg.half_range});
		skin  = (cb_v > cb_lo) && (cb_v < cb_hi) && (cr_v > cr_lo) && (cr_v < cr_hi);

		push_item.skin        = skin;
		push_item.block_col   = col_s2;
		push_item.block_row   = row_s2;
		push_item.emit        = emit_s2;
		push_item.frame_done  = done_s2;
		push_item.frame_start = start_s2;
	end

endmodule

// ===== rtl/skt_queue.sv =====
module skt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  skt_pkg::skt_item_t push_item,
	output logic               full,
	output logic               head_valid,
	output skt_pkg::skt_item_t head_item,
	input  logic               pop
);

	skt_pkg::skt_item_t               q_mem [skt_pkg::QueueDepth];
	logic [skt_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [skt_pkg::QueuePtrW:0]      count_q;

	assign full       = count_q == (skt_pkg::QueuePtrW + 1)'(skt_pkg::QueueDepth);
	assign head_valid = count_q != '0;
	assign head_item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/skt_back.sv =====
module skt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [skt_pkg::CountW-1:0] thresh,
	input  logic                       head_valid,
	input  skt_pkg::skt_item_t         head_item,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 block_col,
	output logic [7:0]                 block_row,
	output logic [14:0]                skin_count,
	output logic                       block_cleared,
	output logic                       frame_done
);

	logic [skt_pkg::CountW-1:0]   count_mem [skt_pkg::ColCount];
	logic [skt_pkg::ColCount-1:0] cnt_valid_q;

	logic                         valid_s3;
	skt_pkg::skt_item_t           item_s3;
	logic [skt_pkg::CountW-1:0]   rdata_s3;
	logic                         fwd_s3;
	logic [skt_pkg::CountW-1:0]   fwd_data_s3;

	logic                         valid_s4;
	logic                         adv_s3;
	logic                         load_s3;
	logic [skt_pkg::CountW-1:0]   old_cnt, new_cnt, wr_cnt;

	assign adv_s3  = valid_s3 && (!item_s3.emit || !valid_s4 || !out_stall);
	assign load_s3 = head_valid && (!valid_s3 || adv_s3);
	assign pop     = load_s3;

	always_comb begin
		if (item_s3.frame_start) begin
			old_cnt = '0;
		end else if (fwd_s3) begin
			old_cnt = fwd_data_s3;
		end else if (cnt_valid_q[item_s3.block_col]) begin
			old_cnt = rdata_s3;
		end else begin
			old_cnt = '0;
		end
		new_cnt = (item_s3.skin && old_cnt != skt_pkg::CountMax) ? old_cnt + 1'b1 : old_cnt;
		wr_cnt  = item_s3.emit ? '0 : new_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			cnt_valid_q <= '0;
		end else begin
			if (load_s3) begin
				valid_s3 <= 1'b1;
			end else if (adv_s3) begin
				valid_s3 <= 1'b0;
			end
			if (adv_s3) begin
				if (item_s3.frame_start) begin
					cnt_valid_q <= {{(skt_pkg::ColCount-1){1'b0}}, 1'b1} << item_s3.block_col;
				end else begin
					cnt_valid_q[item_s3.block_col] <= 1'b1;
				end
			end
			if (adv_s3 && item_s3.emit) begin
				valid_s4 <= 1'b1;
			end else if (!out_stall) begin
				valid_s4 <= 1'b0;
			end
		end
	end

	// counter memory, read on entry, written back when the transaction leaves
	always_ff @(posedge clk) begin
		if (load_s3) begin
			item_s3     <= head_item;
			rdata_s3    <= count_mem[head_item.block_col];
			fwd_s3      <= adv_s3 && (head_item.block_col == item_s3.block_col);
			fwd_data_s3 <= wr_cnt;
		end
		if (adv_s3) begin
			count_mem[item_s3.block_col] <= wr_cnt;
		end
		if (adv_s3 && item_s3.emit) begin
			block_col     <= item_s3.block_col;
			block_row     <= item_s3.block_row;
			skin_count    <= new_cnt;
			block_cleared <= new_cnt <= thresh;
			frame_done    <= item_s3.frame_done;
		end
	end

	assign out_valid = valid_s4;

endmodule

// ===== rtl/block_skin_tone_detector.sv =====
// throughput: one pixel per clock while no stall holds the flow; the counter read-modify-write in the back
//   end runs once per cycle with forwarding between neighboring pixels
// reset: position, block indices and all column counters cleared (per-column
//   valid bits), registers return to their defaults, no transaction pending
module block_skin_tone_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  block_col,
	output logic [7:0]  block_row,
	output logic [14:0] skin_count,
	output logic        block_cleared,
	output logic        frame_done
);

	logic [11:0]              width_q, height_q;
	logic [7:0]               block_q;
	logic [14:0]              thresh_q;
	logic [7:0]               cb_q, cr_q, range_q;
	logic                     cfg_wr;
	skt_pkg::skt_reg_t        reg_sel;
	skt_pkg::skt_cfg_t        cfg;

	logic                     q_push, q_full, q_valid, q_pop;
	skt_pkg::skt_item_t       q_in_item, q_head_item;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = skt_pkg::skt_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			block_q  <= 8'd100;
			thresh_q <= 15'd100;
			cb_q     <= 8'd114;
			cr_q     <= 8'd155;
			range_q  <= 8'd9;
		end else if (cfg_wr) begin
			case (reg_sel)
				skt_pkg::REG_WIDTH:  width_q  <= pwdata[11:0];
				skt_pkg::REG_HEIGHT: height_q <= pwdata[11:0];
				skt_pkg::REG_BLOCK:  block_q  <= pwdata[7:0];
				skt_pkg::REG_THRESH: thresh_q <= pwdata[14:0];
				skt_pkg::REG_CB:     cb_q     <= pwdata[7:0];
				skt_pkg::REG_CR:     cr_q     <= pwdata[7:0];
				skt_pkg::REG_RANGE:  range_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			skt_pkg::REG_WIDTH:  prdata = {20'd0, width_q};
			skt_pkg::REG_HEIGHT: prdata = {20'd0, height_q};
			skt_pkg::REG_BLOCK:  prdata = {24'd0, block_q};
			skt_pkg::REG_THRESH: prdata = {17'd0, thresh_q};
			skt_pkg::REG_CB:     prdata = {24'd0, cb_q};
			skt_pkg::REG_CR:     prdata = {24'd0, cr_q};
			skt_pkg::REG_RANGE:  prdata = {24'd0, range_q};
			default:             prdata = '0;
		endcase
	end

	// clamped limits, kept as last index
	always_comb begin
		if (width_q == 12'd0) begin
			cfg.wm1 = '0;
		end else if (width_q > 12'd2048) begin
			cfg.wm1 = 11'd2047;
		end else begin
			cfg.wm1 = 11'(width_q - 12'd1);
		end
		if (height_q == 12'd0) begin
			cfg.hm1 = '0;
		end else if (height_q > 12'd2048) begin
			cfg.hm1 = 11'd2047;
		end else begin
			cfg.hm1 = 11'(height_q - 12'd1);
		end
		if (block_q < 8'd8) begin
			cfg.bsm1 = 7'd7;
		end else if (block_q > 8'd128) begin
			cfg.bsm1 = 7'd127;
		end else begin
			cfg.bsm1 = 7'(block_q - 8'd1);
		end
		cfg.thresh     = thresh_q;
		cfg.cb_center  = cb_q;
		cfg.cr_center  = cr_q;
		cfg.half_range = range_q;
	end

	skt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_start (frame_start),
		.push        (q_push),
		.push_item   (q_in_item),
		.q_full      (q_full)
	);

	skt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in_item),
		.full       (q_full),
		.head_valid (q_valid),
		.head_item  (q_head_item),
		.pop        (q_pop)
	);

	skt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.thresh        (cfg.thresh),
		.head_valid    (q_valid),
		.head_item     (q_head_item),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.block_col     (block_col),
		.block_row     (block_row),
		.skin_count    (skin_count),
		.block_cleared (block_cleared),
		.frame_done    (frame_done)
	);

endmodule

// ===== rtl/skt_checker.sv =====
module skt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  block_col,
	input logic [7:0]  block_row,
	input logic [14:0] skin_count,
	input logic        block_cleared,
	input logic        frame_done
);

	// a stalled result transaction stays on the port
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({block_col, block_row, skin_count,
			block_cleared, frame_done}))
		else $error("stalled result transaction changed");

	// reset leaves nothing pending and the input open
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("pending transaction during reset");

	// an empty block is always at or below any threshold
	a_zero_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skin_count == 15'd0 |-> block_cleared)
		else $error("block without skin not cleared");

endmodule

bind block_skin_tone_detector skt_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

typedef struct {
	logic [7:0]  block_col;
	logic [7:0]  block_row;
	logic [14:0] skin_count;
	logic        block_cleared;
	logic        frame_done;
} block_report_t;

class skin_block_scoreboard;
	logic [11:0] width_reg, height_reg;
	logic [7:0]  block_reg;
	logic [14:0] thresh_reg;
	logic [7:0]  cb_ctr, cr_ctr, half_win;

	int unsigned pos_x, pos_y, x_in, y_in;
	logic [7:0]  bx_idx, by_idx;
	logic [14:0] col_count[256];

	block_report_t expected_blocks[$];
	int errors;

	function new();
		width_reg = 12'd640;
		height_reg = 12'd480;
		block_reg = 8'd100;
		thresh_reg = 15'd100;
		cb_ctr = 8'd114;
		cr_ctr = 8'd155;
		half_win = 8'd9;
		clear_position();
		errors = 0;
	endfunction

	function void clear_position();
		pos_x = 0;
		pos_y = 0;
		x_in = 0;
		y_in = 0;
		bx_idx = '0;
		by_idx = '0;
		foreach (col_count[i]) col_count[i] = '0;
	endfunction

	function void write_reg(skt_pkg::skt_reg_t idx, logic [31:0] v);
		case (idx)
			skt_pkg::REG_WIDTH:  width_reg = v[11:0];
			skt_pkg::REG_HEIGHT: height_reg = v[11:0];
			skt_pkg::REG_BLOCK:  block_reg = v[7:0];
			skt_pkg::REG_THRESH: thresh_reg = v[14:0];
			skt_pkg::REG_CB:     cb_ctr = v[7:0];
			skt_pkg::REG_CR:     cr_ctr = v[7:0];
			skt_pkg::REG_RANGE:  half_win = v[7:0];
			default: ;
		endcase
	endfunction

	function bit at_frame_origin();
		return pos_x == 0 && pos_y == 0;
	endfunction

	function int pending();
		return expected_blocks.size();
	endfunction

	function bit skin_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned cbq, crq;
		int cbv, crv, lo_cb, hi_cb, lo_cr, hi_cr;
		cbq = 32'd8388608 + 32'd28770 * b - 32'd9699 * r - 32'd19071 * g;
		crq = 32'd8388608 + 32'd28770 * r - 32'd24117 * g - 32'd4653 * b;
		cbv = int'(cbq >> 16);
		crv = int'(crq >> 16);
		lo_cb = int'(cb_ctr) - int'(half_win);
		hi_cb = int'(cb_ctr) + int'(half_win);
		lo_cr = int'(cr_ctr) - int'(half_win);
		hi_cr = int'(cr_ctr) + int'(half_win);
		return cbv > lo_cb && cbv < hi_cb && crv > lo_cr && crv < hi_cr;
	endfunction

	function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
		int unsigned w, h, bs;
		bit row_end, col_end, bx_end, by_end;
		logic [14:0] cnt;
		block_report_t rep;
		w = (width_reg == 0) ? 1 : (width_reg > 2048) ? 2048 : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > 2048) ? 2048 : height_reg;
		bs = (block_reg < 8) ? 8 : (block_reg > 128) ? 128 : block_reg;
		if (fs)
			clear_position();
		if (skin_pixel(r, g, b) && col_count[bx_idx] != 15'h7FFF)
			col_count[bx_idx] = col_count[bx_idx] + 15'd1;
		cnt = col_count[bx_idx];
		row_end = pos_x >= w - 1;
		col_end = pos_y >= h - 1;
		bx_end = row_end || x_in >= bs - 1;
		by_end = col_end || y_in >= bs - 1;
		if (bx_end && by_end) begin
			rep.block_col = bx_idx;
			rep.block_row = by_idx;
			rep.skin_count = cnt;
			rep.block_cleared = cnt <= thresh_reg;
			rep.frame_done = row_end && col_end;
			expected_blocks.push_back(rep);
			col_count[bx_idx] = '0;
		end
		if (row_end) begin
			pos_x = 0;
			x_in = 0;
			bx_idx = '0;
			if (col_end) begin
				pos_y = 0;
				y_in = 0;
				by_idx = '0;
			end else begin
				pos_y = (pos_y + 1) & 'h7FF;
				if (by_end) begin
					y_in = 0;
					by_idx = by_idx + 8'd1;
				end else begin
					y_in = (y_in + 1) & 'h7F;
				end
			end
		end else begin
			pos_x = (pos_x + 1) & 'h7FF;
			if (bx_end) begin
				x_in = 0;
				bx_idx = bx_idx + 8'd1;
			end else begin
				x_in = (x_in + 1) & 'h7F;
			end
		end
	endfunction

	function void compare_field(string name, int unsigned e, int unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	function void check_block(logic [7:0] col, logic [7:0] row, logic [14:0] cnt,
			logic cleared, logic done);
		block_report_t e;
		if (expected_blocks.size() == 0) begin
			$display("%0t: unexpected block result, expected none, actual col %0d row %0d",
				$time, col, row);
			errors++;
			return;
		end
		e = expected_blocks.pop_front();
		compare_field("block_col", e.block_col, col);
		compare_field("block_row", e.block_row, row);
		compare_field("skin_count", e.skin_count, cnt);
		compare_field("block_cleared", e.block_cleared, cleared);
		compare_field("frame_done", e.frame_done, done);
	endfunction
endclass

module testbench;
	localparam int DrainCycles = 12;
	localparam int QuietLimit = 2000;
	localparam int HoldCycles = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  block_col;
	logic [7:0]  block_row;
	logic [14:0] skin_count;
	logic        block_cleared;
	logic        frame_done;

	skin_block_scoreboard sb = new();

	int tx_idle_pct = 11;
	int rx_idle_pct = 60;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	block_skin_tone_detector DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver side stall, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_block(block_col, block_row, skin_count, block_cleared, frame_done);
	end

	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(skt_pkg::skt_reg_t idx, logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(int unsigned w, int unsigned h, int unsigned bs,
			int unsigned th, int unsigned cb, int unsigned cr, int unsigned hr);
		write_reg(skt_pkg::REG_WIDTH, w);
		write_reg(skt_pkg::REG_HEIGHT, h);
		write_reg(skt_pkg::REG_BLOCK, bs);
		write_reg(skt_pkg::REG_THRESH, th);
		write_reg(skt_pkg::REG_CB, cb);
		write_reg(skt_pkg::REG_CR, cr);
		write_reg(skt_pkg::REG_RANGE, hr);
	endtask

	// one input transaction, entered and left at a falling edge
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		frame_start <= fs;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(r, g, b, fs);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
			output logic [7:0] b);
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				r = 8'($urandom_range(170, 230));
				g = 8'($urandom_range(120, 180));
				b = 8'($urandom_range(90, 150));
			end
			4, 5, 6: begin
				r = 8'($urandom_range(255));
				g = 8'($urandom_range(255));
				b = 8'($urandom_range(255));
			end
			7: begin
				r = $urandom_range(1) ? 8'hFF : 8'h00;
				g = $urandom_range(1) ? 8'hFF : 8'h00;
				b = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: begin
				r = 8'($urandom_range(255));
				g = r;
				b = r;
			end
		endcase
	endtask

	task automatic random_frame_pixels(int n, bit force_start);
		logic [7:0] r, g, b;
		logic fs;
		for (int i = 0; i < n; i++) begin
			random_pixel(r, g, b);
			if (force_start && i == 0)
				fs = 1'b1;
			else if (sb.at_frame_origin())
				fs = 1'($urandom_range(1));
			else
				fs = ($urandom_range(99) == 0);
			send_pixel(r, g, b, fs);
		end
	endtask

	task automatic random_config();
		int unsigned v;
		case ($urandom_range(9))
			0: v = 0;
			1: v = $urandom_range(41, 300);
			default: v = $urandom_range(1, 40);
		endcase
		write_reg(skt_pkg::REG_WIDTH, v);
		case ($urandom_range(9))
			0: v = 0;
			1, 2: v = $urandom_range(13, 64);
			default: v = $urandom_range(1, 12);
		endcase
		write_reg(skt_pkg::REG_HEIGHT, v);
		if ($urandom_range(9) < 7) begin
			case ($urandom_range(9))
				0: v = $urandom_range(0, 7);
				1: v = $urandom_range(17, 128);
				2: v = $urandom_range(129, 255);
				default: v = $urandom_range(8, 16);
			endcase
			write_reg(skt_pkg::REG_BLOCK, v);
		end
		if ($urandom_range(9) < 7) begin
			case ($urandom_range(9))
				0, 1: v = 0;
				2: v = 16384;
				3: v = 32767;
				default: v = $urandom_range(0, 40);
			endcase
			write_reg(skt_pkg::REG_THRESH, v);
		end
		if ($urandom_range(9) < 7) begin
			if ($urandom_range(1)) begin
				write_reg(skt_pkg::REG_CB, $urandom_range(100, 125));
				write_reg(skt_pkg::REG_CR, $urandom_range(140, 165));
			end else begin
				write_reg(skt_pkg::REG_CB, $urandom_range(255));
				write_reg(skt_pkg::REG_CR, $urandom_range(255));
			end
		end
		if ($urandom_range(9) < 7) begin
			case ($urandom_range(9))
				0, 1: v = 0;
				2, 3: v = 255;
				4, 5: v = $urandom_range(255);
				default: v = $urandom_range(5, 30);
			endcase
			write_reg(skt_pkg::REG_RANGE, v);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default registers, no block completes
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd200, 8'd150, 8'd120, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		drain();

		// zero sizes act as a one pixel image: every pixel ends a frame
		configure(0, 0, 0, 0, 114, 155, 9);
		send_pixel(8'd200, 8'd150, 8'd120, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd200, 8'd150, 8'd120, 1'b1);
		drain();

		// 3x2 image, all skin, frame restart at the start of the second row
		configure(3, 2, 8, 5, 114, 155, 255);
		for (int i = 0; i < 9; i++)
			send_pixel(8'(i * 28), 8'(255 - i * 28), 8'(i * 17), i == 0);
		for (int i = 0; i < 6; i++)
			send_pixel(8'(i * 40), 8'd128, 8'(255 - i * 40), i == 0);
		drain();

		for (int phase = 0; phase < 16; phase++) begin
			if (phase < 5) begin
				tx_idle_pct = 11;
				rx_idle_pct = 60;
			end else if (phase < 10) begin
				tx_idle_pct = 60;
				rx_idle_pct = 11;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (phase)
				3: begin
					// receiver holds off while results pile up
					configure(2, 1, 255, 32767, 114, 155, 9);
					hold_request = 1'b1;
					random_frame_pixels(60, 1'b1);
				end
				6: begin
					configure(4095, 1, 8, 20, 0, 255, 0);
					random_frame_pixels(150, 1'b1);
				end
				11: begin
					configure(1, 4095, 8, 3, 255, 0, 200);
					random_frame_pixels(100, 1'b1);
				end
				default: begin
					random_config();
					random_frame_pixels($urandom_range(8, 24), 1'b0);
				end
			endcase
			drain();
		end

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
